FILE: rtl/core/bsld_pkg.sv
// Shared constants for the button short/long press detector.
package bsld_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int EVENT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  localparam logic [EVENT_W-1:0] EVT_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EVT_SHORT = 2'd1;
  localparam logic [EVENT_W-1:0] EVT_LONG  = 2'd2;

endpackage

FILE: rtl/core/button_short_long_press_detector_top.sv
// Button press detector: edge debounce, long press while held, short press on release.
// A taken beat's result is registered in the output register, or the skid if stalled.
// Throughput: one pin beat per cycle; a two-entry output stage (register plus skid)
// lets a new beat in while a finished result waits, stall rises only when both are full.
// Reset (rst, synchronous, active high) clears press tracking, both elapsed counters,
// the output stage, and loads the thresholds with 20 and 1000 ticks.
module button_short_long_press_detector_top #(
  parameter int COUNT_WIDTH = bsld_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          pin_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsld_pkg::EVENT_W-1:0]  press_event,
  output logic                          is_pressed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsld_pkg::CFG_W-1:0]    cfg_data
);
  import bsld_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic [CFG_W-1:0]       debounce_ticks;
  logic [CFG_W-1:0]       long_press_ticks;

  logic                   previous_level;
  logic                   press_active;
  logic                   long_fired;
  logic [COUNT_WIDTH-1:0] ticks_since_accept;
  logic [COUNT_WIDTH-1:0] held_ticks;

  logic                   previous_level_next;
  logic                   press_active_next;
  logic                   long_fired_next;
  logic [COUNT_WIDTH-1:0] ticks_since_accept_next;
  logic [COUNT_WIDTH-1:0] held_ticks_next;
  logic [EVENT_W-1:0]     event_next;

  logic                   skid_valid;
  logic [EVENT_W-1:0]     skid_event;
  logic                   skid_pressed;

  logic                   in_take;
  logic                   out_take;

  logic [CMP_W-1:0]       debounce_ext;
  logic [CMP_W-1:0]       long_ext;
  logic [CMP_W-1:0]       since_ext;
  logic [CMP_W-1:0]       held_ext;
  logic                   edge_ok;
  logic                   act0;
  logic                   fired0;
  logic [COUNT_WIDTH-1:0] held0;
  logic [COUNT_WIDTH-1:0] since0;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid & ~skid_valid;
  assign out_take  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    debounce_ext = CMP_W'(debounce_ticks);
    long_ext     = CMP_W'(long_press_ticks);
    since_ext    = CMP_W'(ticks_since_accept);

    // a rising edge restarts tracking only once the debounce time has gone by
    edge_ok = pin_level & ~previous_level & (since_ext >= debounce_ext);
    act0    = press_active | edge_ok;
    fired0  = edge_ok ? 1'b0 : long_fired;
    held0   = edge_ok ? '0 : held_ticks;
    since0  = edge_ok ? '0 : ticks_since_accept;
    held_ext = CMP_W'(held0);

    event_next        = EVT_NONE;
    press_active_next = act0;
    long_fired_next   = fired0;
    held_ticks_next   = held0;

    if (act0) begin
      if (!pin_level) begin
        if (!fired0 && (held_ext >= debounce_ext)) begin
          event_next = EVT_SHORT;
        end
        press_active_next = 1'b0;
        long_fired_next   = 1'b0;
        held_ticks_next   = '0;
      end else if (!fired0 && (held_ext >= long_ext)) begin
        long_fired_next = 1'b1;
        event_next      = EVT_LONG;
      end
    end

    // saturating advance
    ticks_since_accept_next = (&since0) ? since0 : since0 + 1'b1;
    if (press_active_next && !(&held_ticks_next)) begin
      held_ticks_next = held_ticks_next + 1'b1;
    end
    previous_level_next = pin_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level     <= 1'b0;
      press_active       <= 1'b0;
      long_fired         <= 1'b0;
      ticks_since_accept <= '0;
      held_ticks         <= '0;
    end else if (in_take) begin
      previous_level     <= previous_level_next;
      press_active       <= press_active_next;
      long_fired         <= long_fired_next;
      ticks_since_accept <= ticks_since_accept_next;
      held_ticks         <= held_ticks_next;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid) begin
      press_event <= skid_event;
      is_pressed  <= skid_pressed;
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_event   <= event_next;
        skid_pressed <= press_active_next;
      end else begin
        press_event <= event_next;
        is_pressed  <= press_active_next;
      end
    end
  end

endmodule

FILE: rtl/core/bsld_checker.sv
// Port-level checks for the button press detector, bound to the top level.
module bsld_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bsld_pkg::EVENT_W-1:0]   press_event,
  input logic                           is_pressed
);
  import bsld_pkg::*;

  // a short press ends tracking, a long press happens while still held
  a_event_vs_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_event == EVT_NONE) ||
                   (press_event == EVT_SHORT && !is_pressed) ||
                   (press_event == EVT_LONG && is_pressed)))
    else $error("press_event inconsistent with is_pressed");

  // stall only rises when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output stage");

  // after an accepted pin beat the output register holds a result on the next cycle
  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output stage not empty after reset");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(press_event) && $stable(is_pressed)))
    else $error("stalled result changed");

endmodule

bind button_short_long_press_detector_top bsld_checker u_bsld_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the button short/long press detector.
module testbench;
  import bsld_pkg::*;

  localparam int CW              = COUNT_WIDTH_DEFAULT;
  localparam int QUIET_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 200;

  typedef struct packed {
    logic [EVENT_W-1:0] evt;
    logic               pressed;
  } press_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 pin_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [EVENT_W-1:0]   press_event;
  logic                 is_pressed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // predictor state and register copies
  logic             prev_level   = 1'b0;
  logic             tracking     = 1'b0;
  logic             long_done    = 1'b0;
  logic [CW-1:0]    since_accept = '0;
  logic [CW-1:0]    held         = '0;
  logic [CFG_W-1:0] debounce_cfg = DEBOUNCE_RESET;
  logic [CFG_W-1:0] long_cfg     = LONG_PRESS_RESET;

  logic          pin_plan[$];
  press_result_t expected_results[$];
  press_result_t want;

  logic pin_beat         = 1'b0;
  logic gaps_on          = 1'b1;
  logic hold_off_asked   = 1'b0;
  logic hold_off_started = 1'b0;
  int   hold_off_left    = 0;
  int   quiet_cycles     = 0;
  int   mismatches       = 0;
  int   beats_in         = 0;
  int   short_seen       = 0;
  int   long_seen        = 0;
  int   reg_writes       = 0;

  button_short_long_press_detector_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pin_level   (pin_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .press_event (press_event),
    .is_pressed  (is_pressed),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One tick of the detector: edge acceptance, release or long check, then count.
  function automatic press_result_t press_tick(input logic level);
    press_result_t r;
    r.evt = EVT_NONE;
    if (level && !prev_level && since_accept >= debounce_cfg) begin
      tracking     = 1'b1;
      long_done    = 1'b0;
      held         = '0;
      since_accept = '0;
    end
    if (tracking) begin
      if (!level) begin
        if (!long_done && held >= debounce_cfg) r.evt = EVT_SHORT;
        tracking  = 1'b0;
        long_done = 1'b0;
        held      = '0;
      end else if (!long_done && held >= long_cfg) begin
        long_done = 1'b1;
        r.evt     = EVT_LONG;
      end
    end
    if (since_accept != '1) since_accept = since_accept + 1'b1;
    if (tracking && held != '1) held = held + 1'b1;
    prev_level = level;
    r.pressed  = tracking;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int exp_val, input int act_val);
    mismatches++;
    $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
  endtask

  // monitor: take pin beats into the predictor, check result beats
  always @(posedge clk) begin
    pin_beat = 1'b0;
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        expected_results.push_back(press_tick(pin_level));
        pin_beat     = 1'b1;
        beats_in++;
        quiet_cycles = 0;
      end
      if (cfg_valid && cfg_ready) quiet_cycles = 0;
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result beat, press_event", -1, press_event);
        end else begin
          want = expected_results.pop_front();
          if (press_event !== want.evt) note_mismatch("press_event", want.evt, press_event);
          if (is_pressed !== want.pressed)
            note_mismatch("is_pressed", want.pressed, is_pressed);
          if (want.evt == EVT_SHORT) short_seen++;
          if (want.evt == EVT_LONG) long_seen++;
        end
      end
    end
  end

  // driver: advance on an accepted beat or when idle, hold otherwise
  always @(negedge clk) begin
    if (!rst && (!in_valid || pin_beat)) begin
      if (pin_plan.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 25)) begin
        in_valid  <= 1'b1;
        pin_level <= pin_plan.pop_front();
      end else begin
        in_valid  <= 1'b0;
        pin_level <= 1'($urandom_range(0, 1));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_off_asked && !hold_off_started) begin
      hold_off_started = 1'b1;
      hold_off_left    = HOLD_OFF_CYCLES;
    end
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= gaps_on && ($urandom_range(0, 99) < 25);
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL button_short_long_press_detector_top");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DEBOUNCE) debounce_cfg = val;
    else long_cfg = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lng);
  endtask

  // wait until every queued beat is in and every result has come back
  task automatic drain();
    while (pin_plan.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic add_levels(input logic lvl, input int n);
    repeat (n) pin_plan.push_back(lvl);
  endtask

  task automatic add_pattern(input logic [15:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) pin_plan.push_back(bits[i]);
  endtask

  // mostly clean press/release sequences sized around the thresholds, some bounce
  task automatic random_presses(input int items);
    int d;
    int lp;
    int gap;
    int hold;
    int start;
    start = beats_in + pin_plan.size();
    d     = (debounce_cfg > 40) ? 40 : int'(debounce_cfg);
    lp    = (long_cfg > 60) ? 60 : int'(long_cfg);
    while (beats_in + pin_plan.size() - start < items) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          repeat ($urandom_range(1, 6)) pin_plan.push_back(1'($urandom_range(0, 1)));
        end
        9: begin
          add_levels(1'b0, $urandom_range(0, 3 * d + 5));
        end
        default: begin
          gap = $urandom_range(0, d + 4);
          case ($urandom_range(0, 2))
            0:       hold = $urandom_range(1, d + 2);
            1:       hold = $urandom_range(d, lp + 2);
            default: hold = $urandom_range(lp, lp + 8);
          endcase
          if (hold < 1) hold = 1;
          add_levels(1'b0, gap);
          add_levels(1'b1, hold);
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // startup: edges before the debounce time has elapsed are rejected
    add_pattern(16'b110100, 6);
    drain();

    set_thresholds(16'd2, 16'd4);
    add_pattern(16'b001111110, 9);   // long press, then a silent release
    add_pattern(16'b0001110, 7);     // short press
    add_pattern(16'b10, 2);          // edge accepted, but released before a short press counts
    drain();
    write_reg(REG_LONG_PRESS, 16'd0);
    add_pattern(16'b000110, 6);      // zero threshold fires on the accepting tick
    drain();

    set_thresholds(16'd0, 16'd0);
    random_presses(PHASE_ITEMS);
    drain();
    set_thresholds(16'd1, 16'd3);
    random_presses(PHASE_ITEMS);
    drain();
    set_thresholds(16'd5, 16'd25);
    random_presses(PHASE_ITEMS);
    drain();
    set_thresholds(16'hFFFF, 16'd5);
    random_presses(PHASE_ITEMS / 2);
    drain();
    set_thresholds(CFG_W'($urandom), CFG_W'($urandom));
    random_presses(PHASE_ITEMS / 2);
    drain();
    set_thresholds(16'd0, 16'hFFFF);
    random_presses(PHASE_ITEMS);
    drain();

    // no idling on either side for a whole phase
    gaps_on = 1'b0;
    set_thresholds(16'd4, 16'd12);
    random_presses(PHASE_ITEMS);
    drain();
    gaps_on = 1'b1;

    // receiver holds off while beats keep coming, so the input stalls
    set_thresholds(16'd3, 16'd9);
    hold_off_asked = 1'b1;
    random_presses(PHASE_ITEMS);
    drain();

    set_thresholds(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 30)));
    random_presses(PHASE_ITEMS);
    drain();

    // top thresholds: no press is accepted and no event fires
    set_thresholds(16'hFFFF, 16'hFFFF);
    add_levels(1'b0, 20);
    add_levels(1'b1, 20);
    add_levels(1'b0, 2);
    drain();

    repeat (5) @(posedge clk);
    $display("Run covered %0d pin beats and %0d register writes,", beats_in, reg_writes);
    $display("with %0d short and %0d long presses expected.", short_seen, long_seen);
    if (mismatches == 0) begin
      $display("PASS button_short_long_press_detector_top");
    end else begin
      $display("FAIL button_short_long_press_detector_top");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bsld_pkg.sv
rtl/core/button_short_long_press_detector_top.sv
rtl/core/bsld_checker.sv
test/testbench.sv
